// ----- design/svg_pkg.sv -----
// Shared types and constants for the sprite quad vertex generator.
package svg_pkg;

    localparam int COUNT_W     = 11;
    localparam int SLOT_W      = 12;
    localparam int TRIG_W      = 18;
    localparam int PROD_W      = 50;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // sine approximation constants, Q2.14 phase domain
    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;
    localparam int THREE_QUARTER = 49152;
    localparam int FULL_TURN    = 65536;
    localparam int SIN_C0       = 102944;
    localparam int SIN_C1       = 42047;
    localparam int SIN_C2       = 4639;

    typedef enum logic [1:0] {
        ST_VERTEX = 2'd0,
        ST_FLUSH  = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        angle;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic [7:0]         tint_red;
        logic [7:0]         tint_green;
        logic [7:0]         tint_blue;
        logic [7:0]         tint_alpha;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  vertex_slot;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
        logic               tex_u;
        logic               tex_v;
        logic               last;
    } t_vtx_item;

    // classified work item handed from front to back
    typedef struct packed {
        t_status                   kind;
        logic [SLOT_W-1:0]         slot;
        logic signed [31:0]        pos_x;
        logic signed [31:0]        pos_y;
        logic signed [31:0]        pos_z;
        logic [31:0]               tint;
        logic signed [PROD_W-1:0]  p_cx;   // cos * size_x
        logic signed [PROD_W-1:0]  p_sy;   // sin * size_y
        logic signed [PROD_W-1:0]  p_sx;   // sin * size_x
        logic signed [PROD_W-1:0]  p_cy;   // cos * size_y
    } t_job;

endpackage

// ----- design/svg_ifs.sv -----
// Valid/ready stream interfaces for the command and vertex channels.
interface svg_cmd_if import svg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svg_vtx_if import svg_pkg::*; ();
    logic      valid;
    logic      ready;
    t_vtx_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/svg_front.sv -----
// Front end: accepts commands, tracks the quad count, computes sin/cos and size products.
module svg_front
    import svg_pkg::*;
#(
    parameter int MAX_QUADS  = 1024,
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svg_cmd_if.sink     i_cmd,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    localparam int          STAGES     = 6;
    localparam logic [15:0] ANGLE_MASK = 16'(32'hFFFF << (16 - ANGLE_BITS));

    typedef struct packed {
        t_status            kind;
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        tint;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
    } t_front_item;

    logic              adv;
    logic              accept;
    logic [STAGES-1:0] r_vld;
    logic [COUNT_W-1:0] r_count, n_count;

    t_front_item n1_it, r1_it, r2_it, r3_it, r4_it, r5_it;
    logic [15:0] n1_ph [2];
    logic [15:0] r1_ph [2];

    // lane 0 is sine, lane 1 is cosine
    logic signed [TRIG_W-1:0] x_fold [2];
    logic [29:0]              sq     [2];
    logic [27:0]              m1     [2];
    logic [30:0]              pq     [2];
    logic [31:0]              um     [2];
    logic [TRIG_W-1:0]        mag    [2];

    logic [14:0] n2_u [2], r2_u [2], n2_q [2], r2_q [2];
    logic        n2_neg [2], r2_neg [2];
    logic [14:0] r3_u [2], r3_q [2];
    logic        r3_neg [2];
    logic [15:0] n3_inner [2], r3_inner [2];
    logic [14:0] r4_u [2];
    logic        r4_neg [2];
    logic [16:0] n4_m [2], r4_m [2];
    logic signed [TRIG_W-1:0] n5_trig [2], r5_trig [2];

    t_job n6_job, r6_job;

    assign adv         = !r_vld[STAGES-1] || i_job_ready;
    assign accept      = i_cmd.valid && adv;
    assign i_cmd.ready = adv;
    assign o_job_valid = r_vld[STAGES-1];
    assign o_job       = r6_job;

    // classification and quad count
    always_comb begin
        n_count      = r_count;
        n1_it.pos_x  = i_cmd.data.pos_x;
        n1_it.pos_y  = i_cmd.data.pos_y;
        n1_it.pos_z  = i_cmd.data.pos_z;
        n1_it.tint   = {i_cmd.data.tint_red, i_cmd.data.tint_green,
                        i_cmd.data.tint_blue, i_cmd.data.tint_alpha};
        n1_it.size_x = i_cmd.data.size_x;
        n1_it.size_y = i_cmd.data.size_y;
        if (i_cmd.data.cmd == CMD_FLUSH) begin
            n1_it.kind = ST_FLUSH;
            n1_it.slot = SLOT_W'(r_count);
            n_count    = '0;
        end else if (r_count >= COUNT_W'(MAX_QUADS)) begin
            n1_it.kind = ST_FULL;
            n1_it.slot = '0;
        end else begin
            n1_it.kind = ST_VERTEX;
            n1_it.slot = SLOT_W'({r_count, 2'b00});
            n_count    = r_count + COUNT_W'(1);
        end
        n1_ph[0] = i_cmd.data.angle & ANGLE_MASK;
        n1_ph[1] = n1_ph[0] + 16'(QUARTER_TURN);
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            // fold phase into [-1,1] quarter turns
            if (r1_ph[i] <= 16'(QUARTER_TURN)) begin
                x_fold[i] = signed'({2'b00, r1_ph[i]});
            end else if (r1_ph[i] < 16'(THREE_QUARTER)) begin
                x_fold[i] = TRIG_W'(HALF_TURN) - signed'({2'b00, r1_ph[i]});
            end else begin
                x_fold[i] = signed'({2'b00, r1_ph[i]}) - TRIG_W'(FULL_TURN);
            end
            n2_neg[i] = x_fold[i][TRIG_W-1];
            n2_u[i]   = x_fold[i][TRIG_W-1] ? 15'(-x_fold[i]) : 15'(x_fold[i]);
            sq[i]     = {15'd0, n2_u[i]} * {15'd0, n2_u[i]};
            n2_q[i]   = sq[i][28:14];

            m1[i]       = {13'd0, r2_q[i]} * 28'(SIN_C2);
            n3_inner[i] = 16'(SIN_C1) - {2'b00, m1[i][27:14]};

            pq[i]   = {16'd0, r3_q[i]} * {15'd0, r3_inner[i]};
            n4_m[i] = 17'(SIN_C0) - pq[i][30:14];

            um[i]      = {17'd0, r4_u[i]} * {15'd0, r4_m[i]};
            mag[i]     = {1'b0, um[i][30:14]};
            n5_trig[i] = r4_neg[i] ? -signed'(mag[i]) : signed'(mag[i]);
        end
    end

    always_comb begin
        n6_job.kind  = r5_it.kind;
        n6_job.slot  = r5_it.slot;
        n6_job.pos_x = r5_it.pos_x;
        n6_job.pos_y = r5_it.pos_y;
        n6_job.pos_z = r5_it.pos_z;
        n6_job.tint  = r5_it.tint;
        n6_job.p_cx  = PROD_W'(r5_trig[1]) * PROD_W'($signed(r5_it.size_x));
        n6_job.p_sy  = PROD_W'(r5_trig[0]) * PROD_W'($signed(r5_it.size_y));
        n6_job.p_sx  = PROD_W'(r5_trig[0]) * PROD_W'($signed(r5_it.size_x));
        n6_job.p_cy  = PROD_W'(r5_trig[1]) * PROD_W'($signed(r5_it.size_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_count <= '0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[STAGES-2:0], i_cmd.valid};
            end
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_it  <= n1_it;
            r2_it  <= r1_it;
            r3_it  <= r2_it;
            r4_it  <= r3_it;
            r5_it  <= r4_it;
            r6_job <= n6_job;
            for (int i = 0; i < 2; i++) begin
                r1_ph[i]    <= n1_ph[i];
                r2_u[i]     <= n2_u[i];
                r2_q[i]     <= n2_q[i];
                r2_neg[i]   <= n2_neg[i];
                r3_u[i]     <= r2_u[i];
                r3_q[i]     <= r2_q[i];
                r3_neg[i]   <= r2_neg[i];
                r3_inner[i] <= n3_inner[i];
                r4_u[i]     <= r3_u[i];
                r4_neg[i]   <= r3_neg[i];
                r4_m[i]     <= n4_m[i];
                r5_trig[i]  <= n5_trig[i];
            end
        end
    end

endmodule

// ----- design/svg_queue.sv -----
// Short job queue between the front end and the vertex back end.
module svg_queue
    import svg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_fill;
    logic             push, pop;
    t_job             r_slots [QUEUE_DEPTH];

    assign o_push_ready = r_fill != (PTR_W+1)'(QUEUE_DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_pop        = r_slots[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr] <= i_push;
        end
    end

endmodule

// ----- design/svg_back.sv -----
// Back end: walks the four corners of a quad, rounds, translates and saturates.
module svg_back
    import svg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    output logic       o_job_ready,
    input  t_job       i_job,
    svg_vtx_if.source  o_vtx
);

    localparam int RAW_W = PROD_W + 2;
    localparam int SUM_W = RAW_W + 1;
    localparam int FRAC_DROP = 17;

    // per corner: bit set where the unit offset is negative
    localparam logic [3:0] NEG_X = 4'b1001;
    localparam logic [3:0] NEG_Y = 4'b0011;
    localparam logic [3:0] TEX_U = 4'b0110;
    localparam logic [3:0] TEX_V = 4'b1100;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(65536);
    localparam logic signed [SUM_W-1:0] SAT_HI     = (SUM_W'(1) <<< 31) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -(SUM_W'(1) <<< 31);

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic signed [RAW_W-1:0]  raw_x;
        logic signed [RAW_W-1:0]  raw_y;
        logic signed [31:0]       pos_x;
        logic signed [31:0]       pos_y;
        logic signed [31:0]       pos_z;
        logic [31:0]              tint;
        logic                     tex_u;
        logic                     tex_v;
        logic                     last;
    } t_corner;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFFFFFF;
        end else if (v < SAT_LO) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    logic       a_adv, b_adv, fire, is_quad, job_last;
    logic [1:0] r_corner;
    logic       r_a_vld, r_b_vld;
    t_corner    n_a, r_a;
    t_vtx_item  n_b, r_b;

    logic signed [RAW_W-1:0] ext_cx, ext_sy, ext_sx, ext_cy;
    logic signed [SUM_W-1:0] sum_x, sum_y, sh_x, sh_y;

    assign b_adv       = !r_b_vld || o_vtx.ready;
    assign a_adv       = !r_a_vld || b_adv;
    assign is_quad     = i_job.kind == ST_VERTEX;
    assign job_last    = !is_quad || r_corner == 2'd3;
    assign fire        = i_job_valid && a_adv;
    assign o_job_ready = a_adv && job_last;
    assign o_vtx.valid = r_b_vld;
    assign o_vtx.data  = r_b;

    always_comb begin
        ext_cx = RAW_W'($signed(i_job.p_cx));
        ext_sy = RAW_W'($signed(i_job.p_sy));
        ext_sx = RAW_W'($signed(i_job.p_sx));
        ext_cy = RAW_W'($signed(i_job.p_cy));

        n_a.status = i_job.kind;
        n_a.last   = job_last;
        if (is_quad) begin
            n_a.slot  = {i_job.slot[SLOT_W-1:2], r_corner};
            // x = sx*c*w - sy*s*h, y = sx*s*w + sy*c*h
            n_a.raw_x = (NEG_X[r_corner] ? -ext_cx : ext_cx)
                      + (NEG_Y[r_corner] ? ext_sy : -ext_sy);
            n_a.raw_y = (NEG_X[r_corner] ? -ext_sx : ext_sx)
                      + (NEG_Y[r_corner] ? -ext_cy : ext_cy);
            n_a.pos_x = i_job.pos_x;
            n_a.pos_y = i_job.pos_y;
            n_a.pos_z = i_job.pos_z;
            n_a.tint  = i_job.tint;
            n_a.tex_u = TEX_U[r_corner];
            n_a.tex_v = TEX_V[r_corner];
        end else begin
            n_a.slot  = i_job.slot;
            n_a.raw_x = '0;
            n_a.raw_y = '0;
            n_a.pos_x = '0;
            n_a.pos_y = '0;
            n_a.pos_z = '0;
            n_a.tint  = '0;
            n_a.tex_u = 1'b0;
            n_a.tex_v = 1'b0;
        end
    end

    // round to nearest (ties up) folded into the translate add
    always_comb begin
        sum_x = SUM_W'($signed(r_a.raw_x)) + (SUM_W'($signed(r_a.pos_x)) <<< FRAC_DROP)
              + ROUND_HALF;
        sum_y = SUM_W'($signed(r_a.raw_y)) + (SUM_W'($signed(r_a.pos_y)) <<< FRAC_DROP)
              + ROUND_HALF;
        sh_x  = sum_x >>> FRAC_DROP;
        sh_y  = sum_y >>> FRAC_DROP;

        n_b.status      = r_a.status;
        n_b.vertex_slot = r_a.slot;
        n_b.vert_x      = sat32(sh_x);
        n_b.vert_y      = sat32(sh_y);
        n_b.vert_z      = r_a.pos_z;
        n_b.out_red     = r_a.tint[31:24];
        n_b.out_green   = r_a.tint[23:16];
        n_b.out_blue    = r_a.tint[15:8];
        n_b.out_alpha   = r_a.tint[7:0];
        n_b.tex_u       = r_a.tex_u;
        n_b.tex_v       = r_a.tex_v;
        n_b.last        = r_a.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_a_vld  <= 1'b0;
            r_b_vld  <= 1'b0;
        end else begin
            if (fire) begin
                r_corner <= job_last ? 2'd0 : r_corner + 2'd1;
            end
            if (a_adv) begin
                r_a_vld <= i_job_valid;
            end
            if (b_adv) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_a <= n_a;
        end
        if (b_adv && r_a_vld) begin
            r_b <= n_b;
        end
    end

endmodule

// ----- design/sprite_quad_vertex_generator.sv -----
// Sprite quad vertex generator: each add command yields four vertex beats (slot, Q16.16
// position, tint, corner texture coordinate, last on the fourth); a flush yields one beat
// with the quad count and clears it; an add past MAX_QUADS yields one "batch full" beat.
// The vertex port carries one beat per cycle while o_vtx.ready is high, so a quad needs
// four beats and a flush or dropped quad one; that single output port sets the sustained
// rate. A command passes through 6 front stages computing sin/cos and the size products,
// the job queue and 2 back stages. The front end takes a command every cycle until its
// last stage holds a job that the full 4-entry job queue cannot take.
module sprite_quad_vertex_generator
    import svg_pkg::*;
#(
    parameter int MAX_QUADS  = 1024,
    parameter int ANGLE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svg_cmd_if.sink    i_cmd,
    svg_vtx_if.source  o_vtx
);

    logic q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    t_job q_push, q_pop;

    svg_front #(
        .MAX_QUADS  (MAX_QUADS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_job_valid (q_push_valid),
        .i_job_ready (q_push_ready),
        .o_job       (q_push)
    );

    svg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_push       (q_push),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_pop        (q_pop)
    );

    svg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_pop_valid),
        .o_job_ready (q_pop_ready),
        .i_job       (q_pop),
        .o_vtx       (o_vtx)
    );

    // corner index in the slot must agree with last and the texture coordinates
    a_corner_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid && o_vtx.data.status == ST_VERTEX |->
            o_vtx.data.last == (o_vtx.data.vertex_slot[1:0] == 2'd3) &&
            o_vtx.data.tex_u == (o_vtx.data.vertex_slot[0] ^ o_vtx.data.vertex_slot[1]) &&
            o_vtx.data.tex_v == o_vtx.data.vertex_slot[1])
        else $error("vertex corner fields disagree with slot");

    // flush reports and dropped quads are single beats with a cleared position
    a_report_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid && o_vtx.data.status != ST_VERTEX |->
            o_vtx.data.last && o_vtx.data.vert_x == '0 &&
            o_vtx.data.vert_y == '0 && o_vtx.data.vert_z == '0)
        else $error("report beat carries position data or is not last");

    // a job leaves the queue only on its final beat into the back end
    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop_valid && q_pop_ready && q_pop.kind == ST_VERTEX |->
            u_back.r_corner == 2'd3)
        else $error("quad job popped before its fourth corner");

endmodule
